@@ hw/rtl/stac_pkg.sv @@
// Package: shared types and constants for the truncated absolute-difference cost block
`default_nettype none
package stac_pkg;

    // Register index codes of the configuration port
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DISPARITY    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_COST_LIMIT   = 2'd3;

    localparam int unsigned CfgDataW = 13;
    localparam int unsigned PixW     = 8;
    localparam int unsigned CountW   = 12;
    localparam int unsigned HeightCap = 4096;

    // Register reset values
    localparam logic [12:0] LineWidthRst   = 13'd640;
    localparam logic [12:0] FrameHeightRst = 13'd480;
    localparam logic [7:0]  DisparityRst   = 8'd0;
    localparam logic [7:0]  CostLimitRst   = 8'd20;

    // Input word: one left/right pixel pair
    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
    } t_in_word;

    // Output word: one matching cost with its row and frame markers
    typedef struct packed {
        logic [7:0] cost;
        logic       end_of_row;
        logic       end_of_frame;
    } t_out_word;

endpackage
`default_nettype wire

@@ hw/rtl/stereo_truncated_abs_diff_cost.sv @@
// Top level: truncated absolute-difference stereo matching cost for one disparity
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall      | i_in_data  (left, right pixel)
//   out     | output    | o_out_valid / i_out_stall    | o_out_data (cost, eor, eof)
//   cfg     | input     | i_cfg_we, i_cfg_idx          | i_cfg_data
//
// One word per clock while o_in_stall is low; a result becomes valid once its word has
// passed the store read and compare stage, then the output register.
// The delay store holds MAX_DISPARITY right pixels and is read once and written
// once per accepted word; a disparity of zero is forwarded around it.
// Reset clears counters and valids and presets the config; the store needs no clearing.
// An output stall holds the output register; an empty compare stage still fills.
`default_nettype none
module stereo_truncated_abs_diff_cost
    import stac_pkg::*;
#(
    parameter int unsigned MAX_DISPARITY = 256,
    parameter int unsigned MAX_WIDTH     = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_word            i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_word                o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
    localparam logic [AW-1:0] PtrLast = AW'(MAX_DISPARITY - 1);
    localparam int unsigned DispCap = (MAX_DISPARITY - 1 > 255) ? 255 : MAX_DISPARITY - 1;
    localparam int unsigned WidthCap = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;

    // Configuration registers
    logic [12:0] r_line_width;
    logic [12:0] r_frame_height;
    logic [7:0]  r_disparity;
    logic [7:0]  r_cost_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LineWidthRst;
            r_frame_height <= FrameHeightRst;
            r_disparity    <= DisparityRst;
            r_cost_limit   <= CostLimitRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_DISPARITY:    r_disparity    <= i_cfg_data[7:0];
                CFG_COST_LIMIT:   r_cost_limit   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective width, height and disparity
    logic [12:0] width_eff;
    logic [12:0] height_eff;
    logic [7:0]  disp_cap;
    logic [7:0]  disp_eff;

    always_comb begin
        if (r_line_width == 13'd0)
            width_eff = 13'd1;
        else if (r_line_width > 13'(WidthCap))
            width_eff = 13'(WidthCap);
        else
            width_eff = r_line_width;

        if (r_frame_height == 13'd0)
            height_eff = 13'd1;
        else if (r_frame_height > 13'(HeightCap))
            height_eff = 13'(HeightCap);
        else
            height_eff = r_frame_height;

        disp_cap = (r_disparity > 8'(DispCap)) ? 8'(DispCap) : r_disparity;
        disp_eff = (13'(disp_cap) > width_eff) ? width_eff[7:0] : disp_cap;
    end

    // Pipeline handshake
    logic r_v1;
    logic r_ov;
    logic out_free;
    logic s1_free;
    logic accept;

    assign out_free   = !r_ov || !i_out_stall;
    assign s1_free    = !r_v1 || out_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    // Column, row and store pointer
    logic [CountW-1:0] r_col;
    logic [CountW-1:0] r_row;
    logic [AW-1:0]     r_wptr;
    logic [PixW-1:0]   r_first_right;
    logic              eor;
    logic              eof;
    logic              col_wrap;

    assign eor      = (13'(r_col) + 13'd1) >= width_eff;
    assign eof      = eor && ((13'(r_row) + 13'd1) >= height_eff);
    assign col_wrap = eor || (r_col == {CountW{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_wptr        <= '0;
            r_first_right <= '0;
        end else if (accept) begin
            if (r_col == '0)
                r_first_right <= i_in_data.right_pixel;
            // advance column; restart pointer wherever the column restarts
            if (eor) begin
                r_col <= '0;
                r_row <= eof ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
            if (col_wrap || r_wptr == PtrLast)
                r_wptr <= '0;
            else
                r_wptr <= r_wptr + 1'b1;
        end
    end

    // Read address: pointer minus disparity, modulo the store depth
    logic [11:0]   raddr_sub;
    logic [AW-1:0] raddr;

    always_comb begin
        raddr_sub = 12'(r_wptr) - 12'(disp_eff);
        if (12'(r_wptr) < 12'(disp_eff))
            raddr_sub = raddr_sub + 12'(MAX_DISPARITY);
        raddr = raddr_sub[AW-1:0];
    end

    logic [PixW-1:0] rdata;

    stac_delay_mem #(
        .DEPTH (MAX_DISPARITY),
        .AW    (AW)
    ) u_delay_mem (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_waddr (r_wptr),
        .i_wdata (i_in_data.right_pixel),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Compare stage: border pixel or forwarded pixel replaces the store read
    logic            border;
    logic [PixW-1:0] border_pix;
    logic [PixW-1:0] r_alt;
    logic            r_use_alt;
    logic [PixW-1:0] r_left;
    logic            r_eor;
    logic            r_eof;

    assign border     = 13'(r_col) < 13'(disp_eff);
    assign border_pix = (r_col == '0) ? i_in_data.right_pixel : r_first_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v1 <= 1'b0;
        else if (s1_free)
            r_v1 <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_alt     <= border ? border_pix : i_in_data.right_pixel;
            r_use_alt <= border || (disp_eff == 8'd0);
            r_left    <= i_in_data.left_pixel;
            r_eor     <= eor;
            r_eof     <= eof;
        end
    end

    logic [PixW-1:0] compared;
    logic [PixW-1:0] abs_diff;
    logic [PixW-1:0] cost;

    always_comb begin
        compared = r_use_alt ? r_alt : rdata;
        abs_diff = (r_left > compared) ? r_left - compared : compared - r_left;
        cost     = (abs_diff > r_cost_limit) ? r_cost_limit : abs_diff;
    end

    // Output register: hold while stalled
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (out_free)
            r_ov <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_v1) begin
            r_out.cost         <= cost;
            r_out.end_of_row   <= r_eor;
            r_out.end_of_frame <= r_eof;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/stac_delay_mem.sv @@
// Delay store: one-write, one-read synchronous memory of recent right pixels
`default_nettype none
module stac_delay_mem
    import stac_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic [PixW-1:0] i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output logic      [PixW-1:0] o_rdata
);

    logic [PixW-1:0] r_mem [DEPTH];
    logic [PixW-1:0] r_rdata;

    // Write the new pixel and read the delayed one on each accepted word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_waddr] <= i_wdata;
            r_rdata        <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ test/stereo_truncated_abs_diff_cost_tb.sv @@
// Testbench: self-checking pixel-pair stream test of the truncated absolute-difference cost block
`default_nettype none
module stereo_truncated_abs_diff_cost_tb;
    import stac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HISTORY_DEPTH = 256;
    localparam int unsigned WIDTH_CAP     = 4096;
    localparam int unsigned RANDOM_PAIRS  = 1650;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 600_000;
    localparam int unsigned PRINT_LIMIT   = 40;

    // Idle behaviour of either side
    localparam int unsigned IDLE_NONE   = 0;
    localparam int unsigned IDLE_FULL   = 1;
    localparam int unsigned IDLE_SPARSE = 2;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_word  in_data    = '0;
    logic      out_stall  = 1'b0;
    logic      cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx  = CFG_LINE_WIDTH;
    logic [CfgDataW-1:0] cfg_data = '0;

    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_data;

    // Mirror of the block's registers and state
    logic [12:0] cfg_width     = LineWidthRst;
    logic [12:0] cfg_height    = FrameHeightRst;
    logic [7:0]  cfg_disparity = DisparityRst;
    logic [7:0]  cfg_cost_cap  = CostLimitRst;
    logic [7:0]  right_history [HISTORY_DEPTH];
    logic [7:0]  row_first_px  = '0;
    int unsigned column_pos    = 0;
    int unsigned row_pos       = 0;

    t_out_word   expected_costs [$];

    int unsigned in_idle_mode  = IDLE_NONE;
    int unsigned out_idle_mode = IDLE_NONE;
    int unsigned stall_left    = 0;
    int unsigned stall_mark    = 0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned pairs_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned rows_closed    = 0;
    int unsigned frames_closed  = 0;
    int unsigned settings_count = 0;

    stereo_truncated_abs_diff_cost u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Clear the right-pixel history to its reset contents
    initial begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            right_history[i] = '0;
        end
    end

    function automatic int unsigned clamp_size(input logic [12:0] v, input int unsigned cap);
        if (v == 0) begin
            return 1;
        end
        return (v > cap) ? cap : int'(v);
    endfunction

    function automatic int unsigned draw_wait(input int unsigned mode);
        case (mode)
            IDLE_NONE: begin
                return 0;
            end
            IDLE_FULL: begin
                return $urandom_range(0, 18);
            end
            default: begin
                return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // Work out the cost word for one pixel pair and advance the mirrored state
    function automatic t_out_word predict_cost_word(input t_in_word pair);
        int unsigned w;
        int unsigned h;
        int unsigned d;
        int unsigned x;
        int unsigned ref_px;
        int unsigned diff;
        t_out_word   r;
        w = clamp_size(cfg_width, WIDTH_CAP);
        h = clamp_size(cfg_height, HeightCap);
        d = cfg_disparity;
        if (d > w) begin
            d = w;
        end
        x = column_pos;
        if (x == 0) begin
            row_first_px = pair.right_pixel;
        end
        right_history[x % HISTORY_DEPTH] = pair.right_pixel;
        // Border columns compare against the row's first right pixel
        if (x < d) begin
            ref_px = row_first_px;
        end else begin
            ref_px = right_history[(x - d) % HISTORY_DEPTH];
        end
        diff = (pair.left_pixel > ref_px) ? (pair.left_pixel - ref_px)
                                          : (ref_px - pair.left_pixel);
        r.cost         = (diff > cfg_cost_cap) ? cfg_cost_cap : 8'(diff);
        r.end_of_row   = (x + 1 >= w);
        r.end_of_frame = r.end_of_row && (row_pos + 1 >= h);
        if (r.end_of_row) begin
            column_pos = 0;
            row_pos    = r.end_of_frame ? 0 : ((row_pos + 1) & 32'hFFF);
        end else begin
            column_pos = (x + 1) & 32'hFFF;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Write one register; call at a falling edge, returns at the next one
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_LINE_WIDTH: begin
                cfg_width = value;
            end
            CFG_FRAME_HEIGHT: begin
                cfg_height = value;
            end
            CFG_DISPARITY: begin
                cfg_disparity = value[7:0];
            end
            CFG_COST_LIMIT: begin
                cfg_cost_cap = value[7:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [12:0] w, input logic [12:0] h,
                             input logic [7:0] d, input logic [7:0] c);
        write_reg(CFG_LINE_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_DISPARITY, CfgDataW'(d));
        write_reg(CFG_COST_LIMIT, CfgDataW'(c));
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic pick_idling();
        in_idle_mode  = $urandom_range(IDLE_NONE, IDLE_SPARSE);
        out_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
    endtask

    // Offer one pixel pair and hold it until accepted; leaves valid high at a falling edge
    task automatic send_pixel_pair(input logic [7:0] left_px, input logic [7:0] right_px);
        int unsigned gap;
        t_in_word    pair;
        gap = draw_wait(in_idle_mode);
        pair.left_pixel  = left_px;
        pair.right_pixel = right_px;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= pair;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_costs.push_back(predict_cost_word(pair));
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_costs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    // Same-column comparison with the widest cost cap and extreme pixels
    task automatic test_disparity_zero_extremes();
        pick_idling();
        configure(13'd4, 13'd2, 8'd0, 8'd255);
        send_pixel_pair(8'd0, 8'd255);
        send_pixel_pair(8'd255, 8'd0);
        send_pixel_pair(8'd0, 8'd0);
        send_pixel_pair(8'd255, 8'd255);
        send_pixel_pair(8'd128, 8'd127);
        send_pixel_pair(8'd1, 8'd254);
        send_pixel_pair(8'd170, 8'd85);
        send_pixel_pair(8'd85, 8'd170);
        drain_results();
    endtask

    // Border columns against the first right pixel, then shifted compare
    task automatic test_border_columns();
        pick_idling();
        configure(13'd4, 13'd1, 8'd2, 8'd100);
        send_pixel_pair(8'd200, 8'd10);
        send_pixel_pair(8'd10, 8'd200);
        send_pixel_pair(8'd50, 8'd60);
        send_pixel_pair(8'd0, 8'd255);
        drain_results();
    endtask

    // Zero width and height act as one; disparity beyond the width makes all border
    task automatic test_degenerate_sizes();
        pick_idling();
        configure(13'd0, 13'd0, 8'd255, 8'd0);
        send_pixel_pair(8'd255, 8'd0);
        send_pixel_pair(8'd0, 8'd255);
        send_pixel_pair(8'd77, 8'd33);
        drain_results();
    endtask

    // Oversized registers clamp; a narrower width mid-row ends the row at once
    task automatic test_width_cut_mid_row();
        pick_idling();
        configure(13'd8191, 13'd8191, 8'd255, 8'd255);
        send_pixel_pair(8'd10, 8'd240);
        send_pixel_pair(8'd240, 8'd10);
        send_pixel_pair(8'd0, 8'd1);
        send_pixel_pair(8'd255, 8'd128);
        send_pixel_pair(8'd3, 8'd252);
        send_pixel_pair(8'd99, 8'd99);
        drain_results();
        configure(13'd3, 13'd8191, 8'd255, 8'd255);
        send_pixel_pair(8'd200, 8'd20);
        send_pixel_pair(8'd20, 8'd200);
        send_pixel_pair(8'd255, 8'd0);
        drain_results();
    endtask

    // Random settings, mostly whole small frames with random pixels
    task automatic test_random_streams();
        int unsigned w;
        int unsigned h;
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned d;
        int unsigned c;
        int unsigned n;
        int unsigned sel;
        int unsigned start_pairs;
        start_pairs = pairs_sent;
        while (pairs_sent - start_pairs < RANDOM_PAIRS) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                w = $urandom_range(1, 24);
            end else if (sel < 8) begin
                w = $urandom_range(25, 300);
            end else if (sel == 8) begin
                w = 0;
            end else begin
                w = $urandom_range(0, 8191);
            end
            sel = $urandom_range(0, 7);
            if (sel < 5) begin
                h = $urandom_range(1, 5);
            end else if (sel == 5) begin
                h = 0;
            end else if (sel == 6) begin
                h = $urandom_range(6, 40);
            end else begin
                h = $urandom_range(0, 8191);
            end
            eff_w = clamp_size(13'(w), WIDTH_CAP);
            eff_h = clamp_size(13'(h), HeightCap);
            sel = $urandom_range(0, 5);
            if (sel < 3) begin
                d = $urandom_range(0, (eff_w > 256) ? 255 : eff_w - 1);
            end else if (sel == 3) begin
                d = 0;
            end else if (sel == 4) begin
                d = 255;
            end else begin
                d = $urandom_range(0, 255);
            end
            sel = $urandom_range(0, 5);
            if (sel == 0) begin
                c = 0;
            end else if (sel == 1) begin
                c = 255;
            end else begin
                c = $urandom_range(0, 255);
            end
            pick_idling();
            configure(13'(w), 13'(h), 8'(d), 8'(c));
            // Whole frames where small, otherwise a slice that stops mid-frame
            n = (eff_w * eff_h <= 150) ? eff_w * eff_h : $urandom_range(20, 150);
            if ($urandom_range(0, 3) == 0) begin
                n += $urandom_range(1, 10);
            end
            repeat (n) send_pixel_pair(rand_pixel(), rand_pixel());
            drain_results();
        end
    endtask

    // Draw a fresh stall after each result taken
    always @(negedge i_clk) begin
        if (results_seen != stall_mark) begin
            stall_mark = results_seen;
            stall_left = draw_wait(out_idle_mode);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted cost word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen++;
            if (o_out_data.end_of_row) begin
                rows_closed++;
            end
            if (o_out_data.end_of_frame) begin
                frames_closed++;
            end
            if (expected_costs.size() == 0) begin
                report_mismatch($sformatf("unexpected word, cost %0d", o_out_data.cost));
            end else begin
                want = expected_costs.pop_front();
                if (o_out_data.cost !== want.cost) begin
                    report_mismatch($sformatf("word %0d cost %0d, want %0d",
                        results_seen, o_out_data.cost, want.cost));
                end
                if (o_out_data.end_of_row !== want.end_of_row) begin
                    report_mismatch($sformatf("word %0d end_of_row %b, want %b",
                        results_seen, o_out_data.end_of_row, want.end_of_row));
                end
                if (o_out_data.end_of_frame !== want.end_of_frame) begin
                    report_mismatch($sformatf("word %0d end_of_frame %b, want %b",
                        results_seen, o_out_data.end_of_frame, want.end_of_frame));
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                cycle_count, expected_costs.size());
            $display("stereo_truncated_abs_diff_cost_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_disparity_zero_extremes();
        test_border_columns();
        test_degenerate_sizes();
        test_width_cut_mid_row();
        test_random_streams();

        in_valid <= 1'b0;
        while (expected_costs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_costs.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                expected_costs.size()));
        end

        $display("Sent %0d pixel pairs under %0d register settings; checked %0d cost words",
            pairs_sent, settings_count, results_seen);
        $display("Rows closed: %0d, frames closed: %0d, mismatches: %0d",
            rows_closed, frames_closed, mismatch_count);
        if (mismatch_count == 0) begin
            $display("stereo_truncated_abs_diff_cost_tb passed");
        end else begin
            $display("stereo_truncated_abs_diff_cost_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
